@@ sv/ktmpt_pkg.sv @@
package ktmpt_pkg;

  localparam int PRICE_W    = 16;
  localparam int CFG_W      = 6;
  localparam int PROFIT_W   = 21;
  localparam int HOLD_W     = 24;
  localparam int FREE_W     = 22;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  localparam int MAX_TRADES_DEF = 32;
  localparam int MAX_TRADES_LIM = 256;
  localparam int LIM_W          = 9;

  localparam logic [CFG_W-1:0] MAX_TRADES_RST = CFG_W'(1);

  typedef logic signed [HOLD_W-1:0] hold_t;
  typedef logic signed [FREE_W-1:0] free_t;
  typedef logic [PRICE_W-1:0]       price_t;

  localparam hold_t HOLD_INVALID = {1'b1, {(HOLD_W-1){1'b0}}};

endpackage

@@ sv/ktmpt_cell.sv @@
module ktmpt_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            upd,
  input  logic            clr,
  input  ktmpt_pkg::price_t price,
  input  ktmpt_pkg::free_t  below_i,
  output ktmpt_pkg::free_t  free_o,
  output ktmpt_pkg::free_t  free_r_o
);

  ktmpt_pkg::hold_t hold_r, hold_nxt, hold_cur, buy, sell, free_ext;
  ktmpt_pkg::free_t free_r, free_nxt, free_cur;

  always_comb begin
    hold_cur = clr ? ktmpt_pkg::HOLD_INVALID : hold_r;
    free_cur = clr ? '0 : free_r;
    buy      = ktmpt_pkg::HOLD_W'(below_i)
             - $signed({{(ktmpt_pkg::HOLD_W-ktmpt_pkg::PRICE_W){1'b0}}, price});
    hold_nxt = (buy > hold_cur) ? buy : hold_cur;
    sell     = hold_nxt
             + $signed({{(ktmpt_pkg::HOLD_W-ktmpt_pkg::PRICE_W){1'b0}}, price});
    free_ext = ktmpt_pkg::HOLD_W'(free_cur);
    free_nxt = (sell > free_ext) ? sell[ktmpt_pkg::FREE_W-1:0] : free_cur;
  end

  // neighbor above sees this level's value before the current price
  assign free_o   = free_cur;
  assign free_r_o = free_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= ktmpt_pkg::HOLD_INVALID;
      free_r <= '0;
    end else if (upd) begin
      hold_r <= hold_nxt;
      free_r <= free_nxt;
    end
  end

endmodule

@@ sv/k_trade_max_profit_tracker_core.sv @@
// channel | ports              | payload (low bit up)
// in      | in_tvalid/in_tready | tdata: price[15:0]; tuser: new_series
// out     | out_tvalid/out_tready | tdata: best_profit[20:0], zero pad to 24
// cfg     | cfg_wr_en           | cfg_wr_data: max_trades[5:0]
// One price per cycle while in_tready is high; out_tvalid rises once a taken
// price has updated every level cell in parallel and the level given by
// max_trades has then been selected into the output register.
// rst_n clears all levels and sets max_trades to 1.
// An output stall holds one finished result in the cells; input stalls only
// when that stage and the output register are both occupied.
module k_trade_max_profit_tracker_core #(
  parameter int MAX_TRADES = ktmpt_pkg::MAX_TRADES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ktmpt_pkg::IN_DATA_W-1:0]  in_tdata,   // price[15:0]
  input  logic                            in_tuser,   // new_series
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ktmpt_pkg::OUT_DATA_W-1:0] out_tdata,  // best_profit[20:0], pad
  input  logic                            cfg_wr_en,
  input  logic [ktmpt_pkg::CFG_W-1:0]      cfg_wr_data  // max_trades
);

  logic [ktmpt_pkg::CFG_W-1:0] max_trades_r;
  logic                        pend_r, pend_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [ktmpt_pkg::PROFIT_W-1:0] profit_r, profit_sel;
  logic                        accept, move;
  logic [ktmpt_pkg::LIM_W-1:0] lim;

  ktmpt_pkg::free_t chain [MAX_TRADES+1];
  ktmpt_pkg::free_t lvl   [MAX_TRADES];

  assign move      = pend_r && (!out_valid_r || out_tready);
  assign in_tready = !pend_r || move;
  assign accept    = in_tvalid && in_tready;

  assign chain[0] = '0;

  for (genvar m = 0; m < MAX_TRADES; m++) begin : g_lvl
    ktmpt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .upd      (accept),
      .clr      (in_tuser),
      .price    (in_tdata[ktmpt_pkg::PRICE_W-1:0]),
      .below_i  (chain[m]),
      .free_o   (chain[m+1]),
      .free_r_o (lvl[m])
    );
  end

  always_comb begin
    if (ktmpt_pkg::LIM_W'(max_trades_r) > ktmpt_pkg::LIM_W'(MAX_TRADES)) begin
      lim = ktmpt_pkg::LIM_W'(MAX_TRADES);
    end else begin
      lim = ktmpt_pkg::LIM_W'(max_trades_r);
    end
    profit_sel = '0;
    for (int m = 0; m < MAX_TRADES; m++) begin
      if (lim == ktmpt_pkg::LIM_W'(m + 1)) begin
        profit_sel = profit_sel | lvl[m][ktmpt_pkg::PROFIT_W-1:0];
      end
    end
  end

  always_comb begin
    pend_nxt      = accept || (pend_r && !move);
    out_valid_nxt = move || (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_trades_r <= ktmpt_pkg::MAX_TRADES_RST;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_trades_r <= cfg_wr_data;
      end
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      profit_r <= profit_sel;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(ktmpt_pkg::OUT_DATA_W-ktmpt_pkg::PROFIT_W){1'b0}}, profit_r};

  a_accept_pend: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> pend_r)
    else $error("accepted request not pending in cells");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> $stable(profit_r))
    else $error("held result overwritten");

  a_zero_lim: assert property (@(posedge clk) disable iff (!rst_n)
    (move && lim == '0) |=> out_tdata == '0)
    else $error("nonzero profit with no trades allowed");

  a_free_pos: assert property (@(posedge clk) disable iff (!rst_n)
    !lvl[0][ktmpt_pkg::FREE_W-1])
    else $error("negative free value in first level");

endmodule
